[sv/acl_pkg.sv]
// Shared types and constants for the alert cooldown limiter.
// No dependencies; imported by every module of the block.
package acl_pkg;

   localparam int ID_BITS_DEF   = 8;
   localparam int TIME_BITS_DEF = 32;
   localparam int CNT_BITS      = 16;
   localparam int ATT_BITS      = 32;
   localparam int CD_BITS       = 31;
   localparam int CSR_IDX_BITS  = 2;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [CD_BITS-1:0]  COOLDOWN_RESET = 31'd60;
   localparam logic [ATT_BITS-1:0] MAX_SENDS_RESET = 32'd0;
   localparam logic                BACKEND_RESET = 1'b1;

   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_TRIGGER = 1'b1;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_COOLDOWN  = 2'd0,
      CSR_MAX_SENDS = 2'd1,
      CSR_BACKEND   = 2'd2
   } csr_index_type;

   typedef enum logic [1:0] {
      OUT_SENT       = 2'd0,
      OUT_SUPPRESSED = 2'd1,
      OUT_CAPPED     = 2'd2,
      OUT_FAILED     = 2'd3
   } outcome_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] alert_id;
      logic       delivered;
   } req_type;

   typedef struct packed {
      outcome_type         outcome;
      logic [7:0]          result_id;
      logic [CNT_BITS-1:0] resend_count;
   } rsp_type;

   typedef struct packed {
      logic [CD_BITS-1:0]  cooldown_ticks;
      logic [ATT_BITS-1:0] max_total_sends;
      logic                backend_present;
   } cfg_type;

endpackage

[sv/acl_csr.sv]
// Configuration registers of the alert cooldown limiter.
// Depends on acl_pkg.
module acl_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [acl_pkg::CSR_IDX_BITS-1:0]    csr_index,
   input  logic [acl_pkg::CSR_DATA_BITS-1:0]   csr_data,
   output acl_pkg::cfg_type                    cfg
);
   import acl_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_COOLDOWN:  cfg_in.cooldown_ticks  = csr_data[CD_BITS-1:0];
            CSR_MAX_SENDS: cfg_in.max_total_sends = csr_data[ATT_BITS-1:0];
            CSR_BACKEND:   cfg_in.backend_present = csr_data[0];
            default:       cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cooldown_ticks  <= COOLDOWN_RESET;
         cfg_ff.max_total_sends <= MAX_SENDS_RESET;
         cfg_ff.backend_present <= BACKEND_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

endmodule

[sv/acl_table.sv]
// Per-id send time and resend count memory, one read and one write port.
// Registered read with bypass of a same-cycle write; depends on acl_pkg.
module acl_table #(
   parameter int ID_BITS   = acl_pkg::ID_BITS_DEF,
   parameter int TIME_BITS = acl_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          rd_en,
   input  logic [ID_BITS-1:0]            rd_addr,
   output logic [TIME_BITS-1:0]          rd_time,
   output logic [acl_pkg::CNT_BITS-1:0]  rd_count,
   input  logic                          wr_en,
   input  logic [ID_BITS-1:0]            wr_addr,
   input  logic [TIME_BITS-1:0]          wr_time,
   input  logic [acl_pkg::CNT_BITS-1:0]  wr_count
);
   import acl_pkg::*;

   localparam int DEPTH  = 1 << ID_BITS;
   localparam int ENTRY_BITS = TIME_BITS + CNT_BITS;

   logic [ENTRY_BITS-1:0] mem [DEPTH];
   logic [ENTRY_BITS-1:0] rd_data_ff;
   logic [ENTRY_BITS-1:0] fwd_data_ff;
   logic                  fwd_ff;
   logic [ENTRY_BITS-1:0] wr_data;
   logic [ENTRY_BITS-1:0] rd_word;

   assign wr_data = {wr_time, wr_count};

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read-first array; a write to the address being read is bypassed
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff  <= mem[rd_addr];
         fwd_ff      <= wr_en && (wr_addr == rd_addr);
         fwd_data_ff <= wr_data;
      end
   end

   assign rd_word  = fwd_ff ? fwd_data_ff : rd_data_ff;
   assign rd_time  = rd_word[ENTRY_BITS-1:CNT_BITS];
   assign rd_count = rd_word[CNT_BITS-1:0];

endmodule

[sv/acl_core.sv]
// Decision stage: valid bits, time and attempt counters, outcome and result word.
// Depends on acl_pkg; pairs with acl_table for per-id history.
module acl_core #(
   parameter int ID_BITS   = acl_pkg::ID_BITS_DEF,
   parameter int TIME_BITS = acl_pkg::TIME_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          item_valid,
   input  acl_pkg::req_type              item,
   input  acl_pkg::cfg_type              cfg,
   input  logic [TIME_BITS-1:0]          rd_time,
   input  logic [acl_pkg::CNT_BITS-1:0]  rd_count,
   output logic                          wr_en,
   output logic [ID_BITS-1:0]            wr_addr,
   output logic [TIME_BITS-1:0]          wr_time,
   output logic [acl_pkg::CNT_BITS-1:0]  wr_count,
   output logic                          rsp_strobe,
   output acl_pkg::rsp_type              rsp_data
);
   import acl_pkg::*;

   localparam int DEPTH    = 1 << ID_BITS;
   localparam int CMP_BITS = (TIME_BITS > CD_BITS) ? TIME_BITS : CD_BITS;

   logic                  s_valid_ff;
   req_type               s_item_ff;
   logic [DEPTH-1:0]      valid_ff;
   logic [DEPTH-1:0]      valid_in;
   logic [TIME_BITS-1:0]  now_ff;
   logic [TIME_BITS-1:0]  now_in;
   logic [ATT_BITS-1:0]   att_ff;
   logic [ATT_BITS-1:0]   att_in;
   logic                  strobe_ff;
   logic                  strobe_in;
   rsp_type               rsp_ff;
   rsp_type               rsp_in;

   logic [ID_BITS-1:0]    idx;
   logic                  is_trig;
   logic                  is_tick;
   logic                  hit;
   logic [TIME_BITS-1:0]  elapsed;
   logic                  suppressed;
   logic [CNT_BITS-1:0]   next_count;
   logic                  cap_on;
   logic                  blocked;
   logic                  failed;
   logic                  sent;

   always_comb begin
      idx        = ID_BITS'(s_item_ff.alert_id);
      is_trig    = s_valid_ff && (s_item_ff.operation == OP_TRIGGER);
      is_tick    = s_valid_ff && (s_item_ff.operation == OP_TICK);
      hit        = valid_ff[idx];
      elapsed    = now_ff - rd_time;
      suppressed = hit && (CMP_BITS'(elapsed) <= CMP_BITS'(cfg.cooldown_ticks));
      if (!hit) begin
         next_count = '0;
      end else if (rd_count == '1) begin
         next_count = rd_count;
      end else begin
         next_count = rd_count + CNT_BITS'(1);
      end
      cap_on  = (cfg.max_total_sends != '0);
      blocked = cap_on && (att_ff >= cfg.max_total_sends);
      failed  = !blocked && cfg.backend_present && !s_item_ff.delivered;
      sent    = is_trig && !suppressed && !blocked && !failed;

      now_in = is_tick ? now_ff + TIME_BITS'(1) : now_ff;

      att_in = att_ff;
      if (is_trig && !suppressed && cap_on && (att_ff != '1)) begin
         att_in = att_ff + ATT_BITS'(1);
      end

      valid_in = valid_ff;
      if (sent) begin
         valid_in[idx] = 1'b1;
      end

      strobe_in           = is_trig;
      rsp_in.result_id    = s_item_ff.alert_id;
      rsp_in.resend_count = sent ? next_count : '0;
      if (suppressed) begin
         rsp_in.outcome = OUT_SUPPRESSED;
      end else if (blocked) begin
         rsp_in.outcome = OUT_CAPPED;
      end else if (failed) begin
         rsp_in.outcome = OUT_FAILED;
      end else begin
         rsp_in.outcome = OUT_SENT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s_valid_ff <= 1'b0;
         valid_ff   <= '0;
         now_ff     <= '0;
         att_ff     <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         s_valid_ff <= item_valid;
         valid_ff   <= valid_in;
         now_ff     <= now_in;
         att_ff     <= att_in;
         strobe_ff  <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      s_item_ff <= item;
      rsp_ff    <= rsp_in;
   end

   assign wr_en      = sent;
   assign wr_addr    = idx;
   assign wr_time    = now_ff;
   assign wr_count   = next_count;
   assign rsp_strobe = strobe_ff;
   assign rsp_data   = rsp_ff;

endmodule

[sv/alert_cooldown_limiter.sv]
// Top level of the alert cooldown limiter.
// Depends on acl_pkg, acl_csr, acl_table and acl_core.
//
// One word is taken on every clock in which start is high; busy stays low.
// A tick word gives no result; a trigger word gives one result word on
// rsp_strobe, in order, after passing through the input register, which
// the registered read of the per-id history memory runs beside, and then
// the result register. A send's memory write is bypassed to a read of
// the same id issued in the same cycle. Results cannot be held off, so
// they must be taken when rsp_strobe is high. The per-id valid bits clear
// at reset, so no clearing pass follows reset. Configuration writes are
// always ready and belong to idle periods.
module alert_cooldown_limiter #(
   parameter int ID_BITS   = acl_pkg::ID_BITS_DEF,
   parameter int TIME_BITS = acl_pkg::TIME_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  acl_pkg::req_type                   req_data,
   output logic                               rsp_strobe,
   output acl_pkg::rsp_type                   rsp_data,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [acl_pkg::CSR_IDX_BITS-1:0]   csr_index,
   input  logic [acl_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import acl_pkg::*;

   cfg_type               cfg;
   logic                  accept;
   logic [TIME_BITS-1:0]  rd_time;
   logic [CNT_BITS-1:0]   rd_count;
   logic                  wr_en;
   logic [ID_BITS-1:0]    wr_addr;
   logic [TIME_BITS-1:0]  wr_time;
   logic [CNT_BITS-1:0]   wr_count;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   acl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   acl_table #(
      .ID_BITS   (ID_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_table (
      .clock    (clock),
      .rd_en    (accept),
      .rd_addr  (ID_BITS'(req_data.alert_id)),
      .rd_time  (rd_time),
      .rd_count (rd_count),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_time  (wr_time),
      .wr_count (wr_count)
   );

   acl_core #(
      .ID_BITS   (ID_BITS),
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (accept),
      .item       (req_data),
      .cfg        (cfg),
      .rd_time    (rd_time),
      .rd_count   (rd_count),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_time    (wr_time),
      .wr_count   (wr_count),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule

[sv/acl_checker.sv]
// Port-level checks for the alert cooldown limiter, bound to the top level.
// Depends on acl_pkg and alert_cooldown_limiter.
module acl_checker (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  acl_pkg::req_type  req_data,
   input  logic              rsp_strobe,
   input  acl_pkg::rsp_type  rsp_data
);
   import acl_pkg::*;

   // every result word comes from a taken trigger word, through the input and result registers
   a_rsp_from_trigger: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy && (req_data.operation == OP_TRIGGER), 2))
      else $error("result without a trigger two cycles earlier");

   a_rsp_id: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_data.result_id == $past(req_data.alert_id, 2)))
      else $error("result id does not match its trigger");

   a_trigger_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.operation == OP_TRIGGER)) |=> ##1 rsp_strobe)
      else $error("trigger produced no result");

   a_count_only_on_send: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_data.outcome != OUT_SENT)) |-> (rsp_data.resend_count == '0))
      else $error("resend count on an unsent result");

endmodule

bind alert_cooldown_limiter acl_checker u_acl_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .req_data   (req_data),
   .rsp_strobe (rsp_strobe),
   .rsp_data   (rsp_data)
);

[verif/testbench.sv]
// Self-checking testbench for alert_cooldown_limiter: a directed table, then random phases.
// A cycle-free predictor of the cooldown, the global cap and the delivery checks gives the
// expected result words. Depends on acl_pkg and the alert_cooldown_limiter RTL.
module testbench;
   import acl_pkg::*;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE = 2'd3;
   localparam int DRAIN_CYCLES = 4;
   localparam int PHASES       = 12;
   localparam int PHASE_WORDS  = 120;

   typedef enum bit {ROW_WORD, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type              kind;
      logic [CSR_IDX_BITS-1:0]   csr_idx;
      logic [CSR_DATA_BITS-1:0]  csr_val;
      req_type                   word;
      bit                        typed;
      rsp_type                   want;
   } plan_row_type;

   localparam rsp_type NO_RSP = '{OUT_SENT, 8'h00, 16'h0000};

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   req_type                   req_data = '0;
   logic                      rsp_strobe;
   rsp_type                   rsp_data;
   logic                      csr_valid = 1'b0;
   logic                      csr_ready;
   logic [CSR_IDX_BITS-1:0]   csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data = '0;

   // predictor state
   logic [CD_BITS-1:0]   cfg_cooldown;
   logic [ATT_BITS-1:0]  cfg_cap;
   logic                 cfg_backend;
   logic                 hist_valid   [256];
   logic [31:0]          hist_time    [256];
   logic [CNT_BITS-1:0]  hist_resends [256];
   logic [31:0]          tick_now;
   logic [ATT_BITS-1:0]  attempt_count;

   rsp_type      expected_alerts [$];
   int           mismatch_count = 0;
   plan_row_type plan [$];

   alert_cooldown_limiter i_dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #2000000;
      $display("status: fail");
      $finish;
   end

   function automatic plan_row_type word_row(input req_type w);
      plan_row_type r;
      r = '{ROW_WORD, CSR_SPARE, '0, w, 1'b0, NO_RSP};
      return r;
   endfunction

   function automatic plan_row_type word_exp(input req_type w, input rsp_type want);
      plan_row_type r;
      r = '{ROW_WORD, CSR_SPARE, '0, w, 1'b1, want};
      return r;
   endfunction

   function automatic plan_row_type reg_row(input logic [CSR_IDX_BITS-1:0] idx,
                                            input logic [CSR_DATA_BITS-1:0] val);
      plan_row_type r;
      r = '{ROW_CSR, idx, val, '0, 1'b0, NO_RSP};
      return r;
   endfunction

   function automatic void apply_config(input logic [CSR_IDX_BITS-1:0] idx,
                                        input logic [CSR_DATA_BITS-1:0] val);
      case (idx)
         CSR_COOLDOWN:  cfg_cooldown = val[CD_BITS-1:0];
         CSR_MAX_SENDS: cfg_cap = val;
         CSR_BACKEND:   cfg_backend = val[0];
         default: ;
      endcase
   endfunction

   // returns 1 when the word yields a result word
   function automatic bit rate_limit_predict(input req_type w, output rsp_type r);
      logic [31:0]         elapsed;
      logic [CNT_BITS-1:0] nxt;
      outcome_type         verdict;
      logic                blocked;
      r = NO_RSP;
      if (w.operation == OP_TICK) begin
         tick_now = tick_now + 32'd1;
         return 1'b0;
      end
      r.result_id = w.alert_id;
      nxt = '0;
      verdict = OUT_SENT;
      if (hist_valid[w.alert_id]) begin
         elapsed = tick_now - hist_time[w.alert_id];
         if (elapsed <= {1'b0, cfg_cooldown}) begin
            r.outcome = OUT_SUPPRESSED;
            return 1'b1;
         end
         nxt = hist_resends[w.alert_id];
         if (nxt != '1) nxt = nxt + CNT_BITS'(1);
      end
      if (cfg_cap != '0) begin
         blocked = (attempt_count >= cfg_cap);
         if (attempt_count != '1) attempt_count = attempt_count + ATT_BITS'(1);
         if (blocked) verdict = OUT_CAPPED;
      end
      if (verdict == OUT_SENT && cfg_backend && !w.delivered) verdict = OUT_FAILED;
      if (verdict == OUT_SENT) begin
         hist_valid[w.alert_id] = 1'b1;
         hist_time[w.alert_id] = tick_now;
         hist_resends[w.alert_id] = nxt;
         r.resend_count = nxt;
      end
      r.outcome = verdict;
      return 1'b1;
   endfunction

   task automatic send_word(input req_type w, input int gap, input bit typed,
                            input rsp_type want);
      rsp_type predicted;
      bit      yields;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= w;
      do @(posedge clock); while (busy !== 1'b0);
      yields = rate_limit_predict(w, predicted);
      if (yields) expected_alerts.push_back(typed ? want : predicted);
   endtask

   // only while idle: drain results, let trailing ticks settle, then write
   task automatic write_reg(input logic [CSR_IDX_BITS-1:0] idx,
                            input logic [CSR_DATA_BITS-1:0] val);
      start <= 1'b0;
      while (expected_alerts.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (csr_ready !== 1'b1);
      csr_valid <= 1'b0;
      apply_config(idx, val);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_alerts.size() == 0) begin
            $error("unexpected result word: id %0d outcome %0d", rsp_data.result_id,
                   rsp_data.outcome);
            mismatch_count++;
         end else begin
            want = expected_alerts.pop_front();
            if (rsp_data.outcome !== want.outcome) begin
               $error("outcome: expected %0d, got %0d", want.outcome, rsp_data.outcome);
               mismatch_count++;
            end
            if (rsp_data.result_id !== want.result_id) begin
               $error("result_id: expected %0d, got %0d", want.result_id,
                      rsp_data.result_id);
               mismatch_count++;
            end
            if (rsp_data.resend_count !== want.resend_count) begin
               $error("resend_count: expected %0d, got %0d", want.resend_count,
                      rsp_data.resend_count);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      req_type             w;
      logic [31:0]         cd_val;
      logic [31:0]         cap_val;
      logic [7:0]          pool_base;
      int                  pool_size;
      int                  pick;
      bit                  burst;

      cfg_cooldown = COOLDOWN_RESET;
      cfg_cap = MAX_SENDS_RESET;
      cfg_backend = BACKEND_RESET;
      tick_now = '0;
      attempt_count = '0;
      for (int i = 0; i < 256; i++) begin
         hist_valid[i] = 1'b0;
         hist_time[i] = '0;
         hist_resends[i] = '0;
      end

      plan = '{
         word_exp('{OP_TRIGGER, 8'h00, 1'b1}, '{OUT_SENT, 8'h00, 16'd0}),
         word_exp('{OP_TRIGGER, 8'hFF, 1'b1}, '{OUT_SENT, 8'hFF, 16'd0}),
         word_exp('{OP_TRIGGER, 8'h00, 1'b1}, '{OUT_SUPPRESSED, 8'h00, 16'd0}),
         word_exp('{OP_TRIGGER, 8'hAA, 1'b0}, '{OUT_FAILED, 8'hAA, 16'd0}),
         word_row('{OP_TICK, 8'hFF, 1'b1}),
         word_exp('{OP_TRIGGER, 8'h55, 1'b1}, '{OUT_SENT, 8'h55, 16'd0}),
         reg_row(CSR_COOLDOWN, 32'd0),
         word_row('{OP_TRIGGER, 8'h00, 1'b1}),
         word_row('{OP_TRIGGER, 8'h00, 1'b1}),
         word_row('{OP_TICK, 8'h00, 1'b0}),
         word_row('{OP_TRIGGER, 8'h00, 1'b1}),
         reg_row(CSR_SPARE, 32'hFFFF_FFFF),
         reg_row(CSR_BACKEND, 32'd0),
         word_row('{OP_TRIGGER, 8'h0F, 1'b0}),
         reg_row(CSR_MAX_SENDS, 32'd1),
         word_row('{OP_TRIGGER, 8'hF0, 1'b1}),
         word_exp('{OP_TRIGGER, 8'h33, 1'b1}, '{OUT_CAPPED, 8'h33, 16'd0}),
         reg_row(CSR_MAX_SENDS, 32'hFFFF_FFFF),
         word_row('{OP_TRIGGER, 8'h33, 1'b0}),
         reg_row(CSR_BACKEND, 32'd1),
         word_exp('{OP_TRIGGER, 8'h34, 1'b0}, '{OUT_FAILED, 8'h34, 16'd0}),
         reg_row(CSR_COOLDOWN, 32'hFFFF_FFFF),
         word_row('{OP_TICK, 8'h5A, 1'b1}),
         word_row('{OP_TRIGGER, 8'h55, 1'b1}),
         reg_row(CSR_MAX_SENDS, 32'd0)
      };

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR)
            write_reg(plan[i].csr_idx, plan[i].csr_val);
         else
            send_word(plan[i].word, $urandom_range(0, 15), plan[i].typed, plan[i].want);
      end

      for (int p = 0; p < PHASES; p++) begin
         pick = $urandom_range(0, 9);
         if (pick < 6) cd_val = $urandom_range(0, 6);
         else if (pick == 6) cd_val = 32'h7FFF_FFFF;
         else if (pick == 7) cd_val = 32'd60;
         else if (pick == 8) cd_val = 32'd0;
         else cd_val = $urandom;
         pick = $urandom_range(0, 9);
         if (pick < 5) cap_val = 32'd0;
         else if (pick < 9) cap_val = attempt_count + $urandom_range(1, 80);
         else cap_val = 32'hFFFF_FFFF;
         write_reg(CSR_COOLDOWN, cd_val);
         write_reg(CSR_MAX_SENDS, cap_val);
         write_reg(CSR_BACKEND, $urandom);
         if ($urandom_range(0, 3) == 0) write_reg(CSR_SPARE, $urandom);

         pool_base = 8'($urandom_range(0, 255));
         pool_size = ($urandom_range(0, 4) == 0) ? 256 : $urandom_range(1, 8);
         burst = ($urandom_range(0, 3) == 0);
         for (int i = 0; i < PHASE_WORDS; i++) begin
            w.operation = ($urandom_range(0, 2) == 0) ? OP_TICK : OP_TRIGGER;
            if ($urandom_range(0, 9) == 0) w.alert_id = 8'($urandom_range(0, 255));
            else w.alert_id = pool_base + 8'($urandom_range(0, pool_size - 1));
            w.delivered = ($urandom_range(0, 4) != 0);
            send_word(w, burst ? 0 : $urandom_range(0, 15), 1'b0, NO_RSP);
         end
      end

      start <= 1'b0;
      for (int n = 0; n < 200 && expected_alerts.size() != 0; n++) @(posedge clock);
      repeat (8) @(posedge clock);
      if (expected_alerts.size() != 0) begin
         $error("%0d result words never arrived", expected_alerts.size());
         mismatch_count++;
      end
      if (mismatch_count == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[files.f]
sv/acl_pkg.sv
sv/acl_csr.sv
sv/acl_table.sv
sv/acl_core.sv
sv/alert_cooldown_limiter.sv
sv/acl_checker.sv
verif/testbench.sv
